@@ hdl/ffpa_pkg.sv @@
// shared constants and types for the first-fit pool allocator
package ffpa_pkg;
  localparam int POOL_BYTES   = 1024;
  localparam int HEADER_BYTES = 24;
  localparam int MAX_BLOCKS   = 64;
  localparam int MIN_SPLIT    = 4;

  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = IDX_W + 1;
  localparam int SIZE_W = 11;
  localparam int OFF_W  = 10;
  localparam int ENT_W  = SIZE_W + 1;
  localparam int SUM_W  = $clog2(POOL_BYTES) + 3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOMEM   = 2'd1;
  localparam logic [1:0] ST_BADADDR = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [1:0]        status;
    logic [OFF_W-1:0]  payload_offset;
    logic [SIZE_W-1:0] granted_size;
  } ffpa_res_t;
endpackage

@@ hdl/ffpa_if.sv @@
// valid/ready channel interfaces for requests and results
interface ffpa_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [ffpa_pkg::SIZE_W-1:0] alloc_bytes;
  logic [ffpa_pkg::OFF_W-1:0]  addr;
  modport source (output valid, op, alloc_bytes, addr, input ready);
  modport sink (input valid, op, alloc_bytes, addr, output ready);
endinterface

interface ffpa_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [ffpa_pkg::OFF_W-1:0]  payload_offset;
  logic [ffpa_pkg::SIZE_W-1:0] granted_size;
  modport source (output valid, status, payload_offset, granted_size, input ready);
  modport sink (input valid, status, payload_offset, granted_size, output ready);
endinterface

@@ hdl/ffpa_ram.sv @@
// generic single-write, single-read ram with registered read data
module ffpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ hdl/ffpa_ctrl.sv @@
// sequencer: block table scan, split, coalesce and table shifts
module ffpa_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic [ffpa_pkg::SIZE_W-1:0] in_alloc_bytes,
  input  logic [ffpa_pkg::OFF_W-1:0]  in_addr,
  output ffpa_pkg::ffpa_res_t         res,
  input  logic                        res_take,
  output logic                        mem_we,
  output logic [ffpa_pkg::IDX_W-1:0]  mem_waddr,
  output logic [ffpa_pkg::ENT_W-1:0]  mem_wdata,
  output logic                        mem_re,
  output logic [ffpa_pkg::IDX_W-1:0]  mem_raddr,
  input  logic [ffpa_pkg::ENT_W-1:0]  mem_rdata
);
  import ffpa_pkg::*;

  typedef enum logic [12:0] {
    S_INIT = 13'b0000000000001,
    S_IDLE = 13'b0000000000010,
    S_ARD  = 13'b0000000000100,
    S_ACK  = 13'b0000000001000,
    S_FRD  = 13'b0000000010000,
    S_FCK  = 13'b0000000100000,
    S_FNX  = 13'b0000001000000,
    S_FMG  = 13'b0000010000000,
    S_SHRD = 13'b0000100000000,
    S_SHWR = 13'b0001000000000,
    S_AW1  = 13'b0010000000000,
    S_AW0  = 13'b0100000000000,
    S_DONE = 13'b1000000000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [SUM_W-1:0]   off_r, off_nxt;
  logic               op_r, op_nxt;
  logic [SUM_W-1:0]   need_r, need_nxt;
  logic [OFF_W-1:0]   addr_r, addr_nxt;
  logic [IDX_W-1:0]   t_r, t_nxt;
  logic [SIZE_W-1:0]  tsz_r, tsz_nxt;
  logic [SIZE_W-1:0]  psz_r, psz_nxt;
  logic               pfr_r, pfr_nxt;
  logic [SIZE_W-1:0]  nsz_r, nsz_nxt;
  logic               nfr_r, nfr_nxt;
  logic [IDX_W-1:0]   src_r, src_nxt;
  logic [IDX_W-1:0]   dst_r, dst_nxt;
  logic [CNT_W-1:0]   left_r, left_nxt;
  logic               up_r, up_nxt;
  ffpa_res_t          res_r, res_nxt;

  logic [SIZE_W-1:0]  rd_sz;
  logic               rd_fr;
  logic [IDX_W-1:0]   lo;
  logic [CNT_W-1:0]   rm;
  logic [SUM_W-1:0]   merged;

  assign rd_sz = mem_rdata[ENT_W-1:1];
  assign rd_fr = mem_rdata[0];
  assign in_ready = (state_r == S_IDLE);
  assign res = res_r;

  always_comb begin
    lo = pfr_r ? t_r - IDX_W'(1) : t_r;
    rm = CNT_W'(pfr_r) + CNT_W'(nfr_r);
    merged = SUM_W'(tsz_r)
           + (pfr_r ? SUM_W'(psz_r) + SUM_W'(HEADER_BYTES) : '0)
           + (nfr_r ? SUM_W'(nsz_r) + SUM_W'(HEADER_BYTES) : '0);
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    off_nxt   = off_r;
    op_nxt    = op_r;
    need_nxt  = need_r;
    addr_nxt  = addr_r;
    t_nxt     = t_r;
    tsz_nxt   = tsz_r;
    psz_nxt   = psz_r;
    pfr_nxt   = pfr_r;
    nsz_nxt   = nsz_r;
    nfr_nxt   = nfr_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    left_nxt  = left_r;
    up_nxt    = up_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = idx_r[IDX_W-1:0];

    unique case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = {SIZE_W'(POOL_BYTES - HEADER_BYTES), 1'b1};
        count_nxt = CNT_W'(1);
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_op;
          need_nxt = (SUM_W'(in_alloc_bytes) + SUM_W'(3)) & ~SUM_W'(3);
          addr_nxt = in_addr;
          idx_nxt  = '0;
          off_nxt  = '0;
          pfr_nxt  = 1'b0;
          nfr_nxt  = 1'b0;
          res_nxt  = '0;
          if (in_op == OP_ALLOC) begin
            state_nxt = S_ARD;
          end else if (in_addr == '0) begin
            res_nxt.valid = 1'b1;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_FRD;
          end
        end
      end
      S_ARD: begin
        if (idx_r == count_r) begin
          res_nxt.valid  = 1'b1;
          res_nxt.status = ST_NOMEM;
          state_nxt = S_DONE;
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_ACK;
        end
      end
      S_ACK: begin
        if (rd_fr && SUM_W'(rd_sz) >= need_r) begin
          t_nxt   = idx_r[IDX_W-1:0];
          tsz_nxt = rd_sz;
          res_nxt.status = ST_DONE;
          res_nxt.payload_offset = OFF_W'(off_r + SUM_W'(HEADER_BYTES));
          if (SUM_W'(rd_sz) >= need_r + SUM_W'(HEADER_BYTES + MIN_SPLIT)
              && count_r < CNT_W'(MAX_BLOCKS)) begin
            res_nxt.granted_size = SIZE_W'(need_r);
            left_nxt  = count_r - CNT_W'(1) - idx_r;
            src_nxt   = IDX_W'(count_r - CNT_W'(1));
            dst_nxt   = count_r[IDX_W-1:0];
            up_nxt    = 1'b1;
            state_nxt = S_SHRD;
          end else begin
            res_nxt.granted_size = rd_sz;
            state_nxt = S_AW0;
          end
        end else begin
          off_nxt   = off_r + SUM_W'(HEADER_BYTES) + SUM_W'(rd_sz);
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_ARD;
        end
      end
      S_FRD: begin
        if (idx_r == count_r) begin
          res_nxt.valid  = 1'b1;
          res_nxt.status = ST_BADADDR;
          state_nxt = S_DONE;
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_FCK;
        end
      end
      S_FCK: begin
        if (off_r + SUM_W'(HEADER_BYTES) == SUM_W'(addr_r)) begin
          t_nxt   = idx_r[IDX_W-1:0];
          tsz_nxt = rd_sz;
          if (idx_r + CNT_W'(1) < count_r) begin
            mem_re    = 1'b1;
            mem_raddr = IDX_W'(idx_r + CNT_W'(1));
            state_nxt = S_FNX;
          end else begin
            state_nxt = S_FMG;
          end
        end else begin
          psz_nxt   = rd_sz;
          pfr_nxt   = rd_fr;
          off_nxt   = off_r + SUM_W'(HEADER_BYTES) + SUM_W'(rd_sz);
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_FRD;
        end
      end
      S_FNX: begin
        nsz_nxt   = rd_sz;
        nfr_nxt   = rd_fr;
        state_nxt = S_FMG;
      end
      S_FMG: begin
        // neighbors of a free block are never free, so one write merges the target with its free neighbors
        mem_we    = 1'b1;
        mem_waddr = lo;
        mem_wdata = {SIZE_W'(merged), 1'b1};
        res_nxt.status = ST_DONE;
        res_nxt.granted_size = SIZE_W'(merged);
        left_nxt  = count_r - CNT_W'(1) - rm - CNT_W'(lo);
        src_nxt   = IDX_W'(CNT_W'(lo) + CNT_W'(1) + rm);
        dst_nxt   = lo + IDX_W'(1);
        up_nxt    = 1'b0;
        count_nxt = count_r - rm;
        state_nxt = S_SHRD;
      end
      S_SHRD: begin
        if (left_r == '0) begin
          if (op_r == OP_ALLOC) begin
            state_nxt = S_AW1;
          end else begin
            res_nxt.valid = 1'b1;
            state_nxt = S_DONE;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = src_r;
          state_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        mem_we    = 1'b1;
        mem_waddr = dst_r;
        mem_wdata = mem_rdata;
        src_nxt   = up_r ? src_r - IDX_W'(1) : src_r + IDX_W'(1);
        dst_nxt   = up_r ? dst_r - IDX_W'(1) : dst_r + IDX_W'(1);
        left_nxt  = left_r - CNT_W'(1);
        state_nxt = S_SHRD;
      end
      S_AW1: begin
        // free remainder after the split
        mem_we    = 1'b1;
        mem_waddr = t_r + IDX_W'(1);
        mem_wdata = {SIZE_W'(SUM_W'(tsz_r) - need_r - SUM_W'(HEADER_BYTES)), 1'b1};
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_AW0;
      end
      S_AW0: begin
        mem_we    = 1'b1;
        mem_waddr = t_r;
        mem_wdata = {res_r.granted_size, 1'b0};
        res_nxt.valid = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          res_nxt.valid = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      count_r   <= CNT_W'(1);
      res_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      res_r     <= res_nxt;
    end
    idx_r   <= idx_nxt;
    off_r   <= off_nxt;
    op_r    <= op_nxt;
    need_r  <= need_nxt;
    addr_r  <= addr_nxt;
    t_r     <= t_nxt;
    tsz_r   <= tsz_nxt;
    psz_r   <= psz_nxt;
    pfr_r   <= pfr_nxt;
    nsz_r   <= nsz_nxt;
    nfr_r   <= nfr_nxt;
    src_r   <= src_nxt;
    dst_r   <= dst_nxt;
    left_r  <= left_nxt;
    up_r    <= up_nxt;
  end
endmodule

@@ hdl/first_fit_pool_allocator.sv @@
// top level: first-fit pool allocator with block table ram and result register
//
//  channel | dir | word
//  in_ch   | in  | op, alloc_bytes, addr
//  out_ch  | out | status, payload_offset, granted_size
//
// one request at a time; the scan reads and checks each block visited in turn, and
// each table shift on split or merge reads and then writes one moved entry at a time.
// after reset the init state writes the initial block, and in_ch.ready rises in the next cycle.
// a finished word waits in the output register while the next request is taken.
module first_fit_pool_allocator (
  input logic       clk,
  input logic       rst_n,
  ffpa_in_if.sink   in_ch,
  ffpa_out_if.source out_ch
);
  import ffpa_pkg::*;

  ffpa_res_t          res;
  logic               res_take;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENT_W-1:0]   mem_wdata;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;
  logic [ENT_W-1:0]   mem_rdata;
  logic               out_valid_r;
  logic [1:0]         status_r;
  logic [OFF_W-1:0]   offset_r;
  logic [SIZE_W-1:0]  size_r;

  assign res_take = res.valid && (!out_valid_r || out_ch.ready);

  ffpa_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_op          (in_ch.op),
    .in_alloc_bytes (in_ch.alloc_bytes),
    .in_addr        (in_ch.addr),
    .res            (res),
    .res_take       (res_take),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  ffpa_ram #(.WIDTH(ENT_W), .DEPTH(MAX_BLOCKS)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_take) begin
      status_r <= res.status;
      offset_r <= res.payload_offset;
      size_r   <= res.granted_size;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = status_r;
  assign out_ch.payload_offset = offset_r;
  assign out_ch.granted_size   = size_r;
endmodule

@@ hdl/ffpa_checker.sv @@
// port-level checks for the allocator, bound to the top level
module ffpa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  out_status,
  input logic [ffpa_pkg::OFF_W-1:0]  out_payload_offset,
  input logic [ffpa_pkg::SIZE_W-1:0] out_granted_size
);
  import ffpa_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DONE || out_status == ST_NOMEM ||
                   out_status == ST_BADADDR))
    else $error("undefined status");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_payload_offset == '0 &&
                                           out_granted_size == '0)
    else $error("failed request carries data");

  a_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_payload_offset[1:0] == 2'b00 && out_granted_size[1:0] == 2'b00)
    else $error("offset or size not word aligned");
endmodule

bind first_fit_pool_allocator ffpa_checker u_ffpa_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_status         (out_ch.status),
  .out_payload_offset (out_ch.payload_offset),
  .out_granted_size   (out_ch.granted_size)
);
